>>> design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types, constants and pointer arithmetic for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int DEPTH     = 1024;
   localparam int MAX_BURST = 64;
   localparam int PTR_W     = 10;
   localparam int SIZE_W    = 11;
   localparam int LEN_W     = 7;
   localparam int BYTE_W    = 8;
   localparam int STEP_W    = $clog2(PTR_W);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

   typedef enum logic [1:0] {
      FUNC_WRITE     = 2'd0,
      FUNC_READ      = 2'd1,
      FUNC_PEEK      = 2'd2,
      FUNC_PEEK_FROM = 2'd3
   } brb_func_type;

   typedef struct packed {
      brb_func_type        func;
      logic [BYTE_W-1:0]   wr_byte;
      logic [LEN_W-1:0]    req_len;
      logic [PTR_W-1:0]    start_pos;
   } brb_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   rd_byte;
      logic                byte_valid;
      logic                last;
      logic [LEN_W-1:0]    count;
      logic [PTR_W-1:0]    next_pos;
      logic [PTR_W-1:0]    fill_level;
      logic [PTR_W-1:0]    free_space;
   } brb_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_COUNT,
      ST_POINT,
      ST_WRITE,
      ST_LEVEL,
      ST_BURST,
      ST_EMIT
   } brb_state_type;

   // controller -> datapath
   typedef struct packed {
      logic cfg_write;
      logic load;
      logic mod_step;
      logic count_calc;
      logic point_calc;
      logic write_do;
      logic level_calc;
      logic burst_step;
      logic emit_empty;
   } brb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      brb_func_type func;
      logic         mod_last;
      logic         cnt_zero;
      logic         left_last;
   } brb_stat_type;

   // ring size in use, clamped to 2..DEPTH
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] s;
      s = raw;
      if (s < SIZE_MIN) s = SIZE_MIN;
      if (s > SIZE_W'(DEPTH)) s = SIZE_W'(DEPTH);
      return s;
   endfunction

   // p + n, wrapped once at sz
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0]  p,
                                                input logic [LEN_W-1:0]  n,
                                                input logic [SIZE_W-1:0] sz);
      logic [SIZE_W-1:0] s;
      s = {1'b0, p} + SIZE_W'(n);
      if (s >= sz) s = s - sz;
      return s[PTR_W-1:0];
   endfunction

   // bytes between read pointer rp and write pointer wp
   function automatic logic [PTR_W-1:0] used_from(input logic [PTR_W-1:0]  wp,
                                                 input logic [PTR_W-1:0]  rp,
                                                 input logic [SIZE_W-1:0] sz);
      logic [SIZE_W-1:0] d;
      if (wp >= rp) d = {1'b0, wp} - {1'b0, rp};
      else          d = {1'b0, wp} + sz - {1'b0, rp};
      return d[PTR_W-1:0];
   endfunction

endpackage

>>> design/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer for the byte ring buffer: walks each item through its steps.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  brb_pkg::brb_func_type req_func,
   input  logic                  csr_valid,
   input  brb_pkg::brb_stat_type stat,
   output logic                  busy,
   output logic                  csr_ready,
   output brb_pkg::brb_cmd_type  cmd
);
   import brb_pkg::*;

   brb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy          = 1'b0;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            if (start) begin
               cmd.load = 1'b1;
               case (req_func)
                  FUNC_WRITE:     state_in = ST_WRITE;
                  FUNC_PEEK_FROM: state_in = ST_MOD;
                  default:        state_in = ST_COUNT;
               endcase
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count_calc = 1'b1;
            state_in       = ST_POINT;
         end
         ST_POINT: begin
            cmd.point_calc = 1'b1;
            state_in       = ST_LEVEL;
         end
         ST_WRITE: begin
            cmd.write_do = 1'b1;
            state_in     = ST_LEVEL;
         end
         ST_LEVEL: begin
            cmd.level_calc = 1'b1;
            if (stat.func == FUNC_WRITE || stat.cnt_zero) state_in = ST_EMIT;
            else                                          state_in = ST_BURST;
         end
         ST_BURST: begin
            cmd.burst_step = 1'b1;
            if (stat.left_last) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit_empty = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Byte store, pointers, start-position modulo unit and result registers.
// ----------------------------------------------------------------------------
module brb_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  brb_pkg::brb_cmd_type         cmd,
   input  brb_pkg::brb_req_type         req_item,
   input  logic [brb_pkg::SIZE_W-1:0]   csr_data,
   output brb_pkg::brb_stat_type        stat,
   output logic                         rsp_strobe,
   output brb_pkg::brb_rsp_type         rsp_item
);
   import brb_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];

   logic [SIZE_W-1:0] size_ff,   size_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              strobe_ff, strobe_in;

   brb_func_type      func_ff,   func_in;
   logic [BYTE_W-1:0] wb_ff,     wb_in;
   logic [LEN_W-1:0]  req_ff,    req_in;
   logic [PTR_W-1:0]  shift_ff,  shift_in;
   logic [PTR_W-1:0]  rem_ff,    rem_in;
   logic [STEP_W-1:0] step_ff,   step_in;
   logic [PTR_W-1:0]  rp_ff,     rp_in;
   logic [PTR_W-1:0]  addr_ff,   addr_in;
   logic [LEN_W-1:0]  cnt_ff,    cnt_in;
   logic [LEN_W-1:0]  left_ff,   left_in;
   logic [PTR_W-1:0]  next_ff,   next_in;
   logic [PTR_W-1:0]  fill_ff,   fill_in;
   logic [PTR_W-1:0]  free_ff,   free_in;
   logic              bvalid_ff, bvalid_in;
   logic              last_ff,   last_in;
   logic [BYTE_W-1:0] rdata_ff;

   logic [SIZE_W-1:0] sz;
   logic [SIZE_W-1:0] shifted;
   logic [SIZE_W-1:0] rem_step;
   logic [PTR_W-1:0]  avail;
   logic [PTR_W-1:0]  fill_now;
   logic [SIZE_W-1:0] free_now;
   logic              full;
   logic [PTR_W-1:0]  sum_pt;
   logic [PTR_W-1:0]  wr_inc;
   logic [PTR_W-1:0]  addr_inc;
   logic [LEN_W-1:0]  req_sat;

   always_comb begin
      sz       = eff_size(size_ff);
      shifted  = {rem_ff, shift_ff[PTR_W-1]};
      rem_step = (shifted >= sz) ? shifted - sz : shifted;
      avail    = used_from(wr_ptr_ff, rp_ff, sz);
      fill_now = used_from(wr_ptr_ff, rd_ptr_ff, sz);
      free_now = sz - {1'b0, fill_now} - SIZE_W'(1);
      full     = (free_now == '0);
      sum_pt   = wrap_add(rp_ff, cnt_ff, sz);
      wr_inc   = wrap_add(wr_ptr_ff, LEN_W'(1), sz);
      addr_inc = wrap_add(addr_ff, LEN_W'(1), sz);
      req_sat  = (req_item.req_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                       : req_item.req_len;
   end

   always_comb begin
      size_in   = size_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      strobe_in = 1'b0;
      func_in   = func_ff;
      wb_in     = wb_ff;
      req_in    = req_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      rp_in     = rp_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      next_in   = next_ff;
      fill_in   = fill_ff;
      free_in   = free_ff;
      bvalid_in = bvalid_ff;
      last_in   = last_ff;

      // new size empties the ring
      if (cmd.cfg_write) begin
         size_in   = csr_data;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end
      if (cmd.load) begin
         func_in  = req_item.func;
         wb_in    = req_item.wr_byte;
         req_in   = req_sat;
         shift_in = req_item.start_pos;
         rem_in   = '0;
         step_in  = STEP_W'(PTR_W - 1);
         rp_in    = rd_ptr_ff;
      end
      // restoring remainder, one bit of start_pos per step
      if (cmd.mod_step) begin
         rem_in   = rem_step[PTR_W-1:0];
         shift_in = {shift_ff[PTR_W-2:0], 1'b0};
         step_in  = step_ff - STEP_W'(1);
         if (step_ff == '0) rp_in = rem_step[PTR_W-1:0];
      end
      if (cmd.count_calc) begin
         cnt_in  = (PTR_W'(req_ff) < avail) ? req_ff : avail[LEN_W-1:0];
         addr_in = rp_ff;
      end
      if (cmd.point_calc) begin
         next_in = (func_ff == FUNC_PEEK) ? rd_ptr_ff : sum_pt;
         if (func_ff == FUNC_READ) rd_ptr_in = sum_pt;
         left_in = cnt_ff;
      end
      if (cmd.write_do) begin
         if (!full) wr_ptr_in = wr_inc;
         cnt_in = full ? LEN_W'(0) : LEN_W'(1);
      end
      if (cmd.level_calc) begin
         fill_in = fill_now;
         free_in = free_now[PTR_W-1:0];
         if (func_ff == FUNC_WRITE) next_in = wr_ptr_ff;
      end
      if (cmd.burst_step) begin
         addr_in   = addr_inc;
         left_in   = left_ff - LEN_W'(1);
         strobe_in = 1'b1;
         bvalid_in = 1'b1;
         last_in   = (left_ff == LEN_W'(1));
      end
      if (cmd.emit_empty) begin
         strobe_in = 1'b1;
         bvalid_in = 1'b0;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RESET;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         size_ff   <= size_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      wb_ff     <= wb_in;
      req_ff    <= req_in;
      shift_ff  <= shift_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      rp_ff     <= rp_in;
      addr_ff   <= addr_in;
      cnt_ff    <= cnt_in;
      left_ff   <= left_in;
      next_ff   <= next_in;
      fill_ff   <= fill_in;
      free_ff   <= free_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_do && !full) mem[wr_ptr_ff] <= wb_ff;
      if (cmd.burst_step) rdata_ff <= mem[addr_ff];
   end

   always_comb begin
      stat.func      = func_ff;
      stat.mod_last  = (step_ff == '0);
      stat.cnt_zero  = (cnt_ff == '0);
      stat.left_last = (left_ff == LEN_W'(1));
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_item.rd_byte    = bvalid_ff ? rdata_ff : '0;
   assign rsp_item.byte_valid = bvalid_ff;
   assign rsp_item.last       = last_ff;
   assign rsp_item.count      = cnt_ff;
   assign rsp_item.next_pos   = next_ff;
   assign rsp_item.fill_level = fill_ff;
   assign rsp_item.free_space = free_ff;

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff < sz[PTR_W:0] && wr_ptr_ff < sz[PTR_W:0])
      else $error("pointer outside ring in use");

   a_burst_has_bytes: assert property (@(posedge clock) disable iff (reset)
      cmd.burst_step |-> left_ff != '0)
      else $error("burst step with no bytes left");

   a_level_sums: assert property (@(posedge clock) disable iff (reset)
      cmd.level_calc |=> {1'b0, fill_ff} + {1'b0, free_ff} + SIZE_W'(1) == sz)
      else $error("fill and free do not add up to ring size");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.point_calc |-> cnt_ff <= LEN_W'(MAX_BURST))
      else $error("count above burst limit");

endmodule

>>> design/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte FIFO with programmable ring size, one slot kept empty.
// ----------------------------------------------------------------------------
// Usage:
//  - Items: drive req_item and raise start; the item is taken on a clock edge
//    where start is high and busy is low. func selects write, read, peek or
//    peek-from.
//  - Results: each result item is on rsp_item for one cycle with rsp_strobe
//    high; the receiver has no way to stall, it must take every strobe.
//    rsp_item.last marks the final result of an item.
//  - Config: ring_size is written over csr_valid/csr_ready/csr_data; ready is
//    high only while idle. A write also empties the ring.
//  - Sequence: a write passes the write, level and emit steps and gives a
//    single result. A read or peek of n bytes passes the count, point and
//    level steps, then gives one byte per burst step; with no bytes it
//    gives one empty result. Peek-from first runs the start-position
//    modulo, one remainder bit per cycle.
//  - Throughput: one item at a time; the byte store's single read port
//    moves one byte per cycle during a burst. busy drops in the cycle the
//    final strobe shows, so the next item can be taken right then.
//  - Reset: ring_size returns to 1024 and both pointers to 0 (empty ring).
//    Store contents are not cleared; slots never written read as garbage.
// ----------------------------------------------------------------------------
module byte_ring_buffer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  brb_pkg::brb_req_type         req_item,
   output logic                         rsp_strobe,
   output brb_pkg::brb_rsp_type         rsp_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [brb_pkg::SIZE_W-1:0]   csr_data
);
   import brb_pkg::*;

   brb_cmd_type  cmd;
   brb_stat_type stat;

   // sequencer: one state per step of an item
   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_item.func),
      .csr_valid (csr_valid),
      .stat      (stat),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // store, pointers, modulo unit and result registers
   brb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .csr_data   (csr_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
